@@ hdl/chat_format_code_stripper_top_assert.svh @@
// ----------------------------------------------------------------------------
// Chat format code stripper assertion macros
// Implication checks on the top-level ports, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef CHAT_FORMAT_CODE_STRIPPER_TOP_ASSERT_SVH
`define CHAT_FORMAT_CODE_STRIPPER_TOP_ASSERT_SVH

// same-cycle implication
`define CFS_ASSERT_IMPLY(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("cfs same-cycle check failed");

// next-cycle implication
`define CFS_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("cfs next-cycle check failed");

`endif

@@ hdl/cfs_pkg.sv @@
// ----------------------------------------------------------------------------
// Chat format code stripper package
// Character codes, parse phases, result word layout and strip decode.
// ----------------------------------------------------------------------------
package cfs_pkg;

  localparam logic [7:0] ChBold      = 8'h02;
  localparam logic [7:0] ChColor     = 8'h03;
  localparam logic [7:0] ChPlain     = 8'h0F;
  localparam logic [7:0] ChReverse   = 8'h16;
  localparam logic [7:0] ChUnderline = 8'h1F;
  localparam logic [7:0] ChComma     = 8'h2C;
  localparam logic [7:0] ChDigit0    = 8'h30;
  localparam logic [7:0] ChDigit9    = 8'h39;

  localparam int unsigned SelW      = 6;
  localparam int unsigned SelColor  = 0;
  localparam int unsigned SelRev    = 1;
  localparam int unsigned SelUnder  = 2;
  localparam int unsigned SelBold   = 3;
  localparam int unsigned SelPlain  = 4;
  localparam int unsigned SelAll    = 5;
  localparam logic [SelW-1:0] SelReset = 6'd63;

  localparam int unsigned AddrW = 3;
  localparam int unsigned DataW = 32;
  localparam logic [AddrW-1:0] RegStripSelect = 3'd0;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = 2;
  localparam int unsigned FifoCntW  = 3;

  typedef enum logic [5:0] {
    PhNormal = 6'b000001,
    PhColor  = 6'b000010,
    PhFg1    = 6'b000100,
    PhFg2    = 6'b001000,
    PhHeld   = 6'b010000,
    PhBg1    = 6'b100000
  } phase_e;

  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       eot;
  } result_t;

  typedef struct packed {
    result_t    r0;
    result_t    r1;
    logic [1:0] count;
    phase_e     next_phase;
  } parse_t;

  function automatic logic will_strip(input logic [7:0] b, input logic [SelW-1:0] sel);
    logic [SelW-1:0] eff;
    logic            res;
    eff = sel[SelAll] ? {SelW{1'b1}} : sel;
    unique case (b)
      ChColor:     res = eff[SelColor];
      ChReverse:   res = eff[SelRev];
      ChUnderline: res = eff[SelUnder];
      ChBold:      res = eff[SelBold];
      ChPlain:     res = eff[SelPlain];
      default:     res = 1'b0;
    endcase
    return res;
  endfunction

endpackage

@@ hdl/cfs_parser.sv @@
// ----------------------------------------------------------------------------
// Chat format code stripper parser
// Decodes one text byte against the parse phase into up to two result words.
// ----------------------------------------------------------------------------
module cfs_parser (
  input  cfs_pkg::phase_e          phase_i,
  input  logic [7:0]               text_byte_i,
  input  logic                     text_last_i,
  input  logic [cfs_pkg::SelW-1:0] sel_i,
  output cfs_pkg::parse_t          parse_o
);

  logic            dig;
  logic            comma;
  logic            strip;
  logic            col;
  logic            pre;
  logic            keep;
  logic            post;
  logic            cnt2;
  logic            cnt1;
  cfs_pkg::phase_e ph;
  cfs_pkg::phase_e ph_plain;

  always_comb begin
    dig      = (text_byte_i >= cfs_pkg::ChDigit0) && (text_byte_i <= cfs_pkg::ChDigit9);
    comma    = (text_byte_i == cfs_pkg::ChComma);
    strip    = cfs_pkg::will_strip(text_byte_i, sel_i);
    col      = strip && (text_byte_i == cfs_pkg::ChColor);
    ph_plain = col ? cfs_pkg::PhColor : cfs_pkg::PhNormal;
    pre      = 1'b0;
    keep     = 1'b0;
    ph       = cfs_pkg::PhNormal;
    unique case (phase_i)
      cfs_pkg::PhColor: begin
        if (dig) begin
          ph = cfs_pkg::PhFg1;
        end else begin
          keep = !strip;
          ph   = ph_plain;
        end
      end
      cfs_pkg::PhFg1: begin
        if (dig) begin
          ph = cfs_pkg::PhFg2;
        end else if (comma) begin
          ph = cfs_pkg::PhHeld;
        end else begin
          keep = !strip;
          ph   = ph_plain;
        end
      end
      cfs_pkg::PhFg2: begin
        if (comma) begin
          ph = cfs_pkg::PhHeld;
        end else begin
          keep = !strip;
          ph   = ph_plain;
        end
      end
      cfs_pkg::PhHeld: begin
        if (dig) begin
          ph = cfs_pkg::PhBg1;
        end else begin
          pre  = 1'b1;
          keep = !strip;
          ph   = ph_plain;
        end
      end
      cfs_pkg::PhBg1: begin
        if (!dig) begin
          keep = !strip;
          ph   = ph_plain;
        end
      end
      default: begin
        keep = !strip;
        ph   = ph_plain;
      end
    endcase

    post = text_last_i && (ph == cfs_pkg::PhHeld);
    if (text_last_i) begin
      ph = cfs_pkg::PhNormal;
    end

    cnt2 = (pre && keep) || (keep && post);
    cnt1 = !cnt2 && (pre || keep || post || text_last_i);

    if (pre || post) begin
      parse_o.r0.data    = cfs_pkg::ChComma;
      parse_o.r0.present = 1'b1;
    end else if (keep) begin
      parse_o.r0.data    = text_byte_i;
      parse_o.r0.present = 1'b1;
    end else begin
      parse_o.r0.data    = 8'h00;
      parse_o.r0.present = 1'b0;
    end
    if (pre && keep) begin
      parse_o.r1.data = text_byte_i;
    end else begin
      parse_o.r1.data = cfs_pkg::ChComma;
    end
    parse_o.r1.present = cnt2;
    // text byte goes first when the trailing comma follows it
    if (keep && post) begin
      parse_o.r0.data = text_byte_i;
    end
    parse_o.r0.eot      = text_last_i && !cnt2;
    parse_o.r1.eot      = text_last_i && cnt2;
    parse_o.count       = {cnt2, cnt1};
    parse_o.next_phase  = ph;
  end

endmodule

@@ hdl/cfs_out_fifo.sv @@
// ----------------------------------------------------------------------------
// Chat format code stripper output queue
// Takes up to two result words per cycle, hands out one per cycle on pop.
// ----------------------------------------------------------------------------
module cfs_out_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  cfs_pkg::parse_t  parse_i,
  input  logic             pop_i,
  output cfs_pkg::result_t head_o,
  output logic             valid_o,
  output logic             full_o
);

  cfs_pkg::result_t                 mem_q [cfs_pkg::FifoDepth];
  logic [cfs_pkg::FifoPtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [cfs_pkg::FifoPtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [cfs_pkg::FifoCntW-1:0]     cnt_q, cnt_d;
  logic [cfs_pkg::FifoCntW-1:0]     push_n;
  logic [cfs_pkg::FifoPtrW-1:0]     wr_ptr_nx;

  always_comb begin
    push_n    = push_i ? cfs_pkg::FifoCntW'(parse_i.count) : '0;
    wr_ptr_nx = wr_ptr_q + cfs_pkg::FifoPtrW'(1);
    wr_ptr_d  = wr_ptr_q + push_n[cfs_pkg::FifoPtrW-1:0];
    rd_ptr_d  = rd_ptr_q + cfs_pkg::FifoPtrW'(pop_i);
    cnt_d     = cnt_q + push_n - cfs_pkg::FifoCntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && (parse_i.count != 2'd0)) begin
      mem_q[wr_ptr_q] <= parse_i.r0;
    end
    if (push_i && parse_i.count[1]) begin
      mem_q[wr_ptr_nx] <= parse_i.r1;
    end
  end

  assign head_o  = mem_q[rd_ptr_q];
  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q >= cfs_pkg::FifoCntW'(cfs_pkg::FifoDepth - 1));

endmodule

@@ hdl/chat_format_code_stripper_top.sv @@
// ----------------------------------------------------------------------------
// Chat format code stripper
// Removes selected chat formatting codes from a byte stream.
//
//   channel   direction  handshake              payload
//   in        sink       in_valid_i/in_stall_o  text_byte_i, text_last_i
//   out       source     out_valid_o/out_stall_i out_byte_o, byte_present_o,
//                                               end_of_text_o
//   config    APB        psel/penable/pwrite    paddr, pwdata, prdata
//
// One input word per cycle while in_stall_o is low; each word yields zero to
// two output words, one leaves per cycle while out_stall_i is low, so a run
// of two-word results throttles the input. The phase update sets the input rate.
// Accepted results are written into a four-word output queue.
// Reset empties the queue, sets the phase to normal text and the select to 63.
// Input stalls while the queue holds three or more words.
// ----------------------------------------------------------------------------
module chat_format_code_stripper_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [7:0]                text_byte_i,
  input  logic                      text_last_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [7:0]                out_byte_o,
  output logic                      byte_present_o,
  output logic                      end_of_text_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [cfs_pkg::AddrW-1:0] paddr,
  input  logic [cfs_pkg::DataW-1:0] pwdata,
  output logic [cfs_pkg::DataW-1:0] prdata,
  output logic                      pready
);

  logic [cfs_pkg::SelW-1:0] sel_q, sel_d;
  cfs_pkg::phase_e          phase_q, phase_d;
  cfs_pkg::parse_t          parse;
  cfs_pkg::result_t         head;
  logic                     accept;
  logic                     pop;
  logic                     full;
  logic                     sel_wr;

  assign pready = 1'b1;
  assign sel_wr = psel && penable && pwrite && (paddr == cfs_pkg::RegStripSelect);
  assign prdata = (paddr == cfs_pkg::RegStripSelect)
                ? cfs_pkg::DataW'(sel_q) : '0;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;
  assign pop        = out_valid_o && !out_stall_i;

  always_comb begin
    sel_d   = sel_wr ? pwdata[cfs_pkg::SelW-1:0] : sel_q;
    phase_d = accept ? parse.next_phase : phase_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q   <= cfs_pkg::SelReset;
      phase_q <= cfs_pkg::PhNormal;
    end else begin
      sel_q   <= sel_d;
      phase_q <= phase_d;
    end
  end

  cfs_parser u_parser (
    .phase_i     (phase_q),
    .text_byte_i (text_byte_i),
    .text_last_i (text_last_i),
    .sel_i       (sel_q),
    .parse_o     (parse)
  );

  cfs_out_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .parse_i (parse),
    .pop_i   (pop),
    .head_o  (head),
    .valid_o (out_valid_o),
    .full_o  (full)
  );

  assign out_byte_o     = head.data;
  assign byte_present_o = head.present;
  assign end_of_text_o  = head.eot;

endmodule

@@ hdl/cfs_checker.sv @@
// ----------------------------------------------------------------------------
// Chat format code stripper port checker
// Watches the top-level ports for result word and register consistency.
// ----------------------------------------------------------------------------
`include "chat_format_code_stripper_top_assert.svh"

module cfs_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic [7:0]                out_byte_o,
  input logic                      byte_present_o,
  input logic                      end_of_text_o,
  input logic                      psel,
  input logic                      penable,
  input logic                      pwrite,
  input logic [cfs_pkg::AddrW-1:0] paddr,
  input logic [cfs_pkg::DataW-1:0] pwdata,
  input logic [cfs_pkg::DataW-1:0] prdata
);

  logic                     empty_word;
  logic                     out_hold;
  logic [10:0]              out_word;
  logic                     rd_sel;
  logic                     sel_wr;
  logic [cfs_pkg::SelW-1:0] wdata;

  assign empty_word = out_valid_o && !byte_present_o;
  assign out_hold   = out_valid_o && out_stall_i;
  assign out_word   = {out_valid_o, byte_present_o, end_of_text_o, out_byte_o};
  assign rd_sel     = (paddr == cfs_pkg::RegStripSelect);
  assign sel_wr     = psel && penable && pwrite && rd_sel;
  assign wdata      = pwdata[cfs_pkg::SelW-1:0];

  `CFS_ASSERT_IMPLY(a_empty_is_end, clk_i, rst_ni, empty_word, end_of_text_o)
  `CFS_ASSERT_IMPLY(a_empty_is_zero, clk_i, rst_ni, empty_word, out_byte_o == 8'h00)
  `CFS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_hold, out_valid_o && $stable(out_word))
  `CFS_ASSERT_NEXT(a_sel_write, clk_i, rst_ni, sel_wr, !rd_sel || prdata == cfs_pkg::DataW'($past(wdata)))

endmodule

bind chat_format_code_stripper_top cfs_checker u_cfs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .out_byte_o     (out_byte_o),
  .byte_present_o (byte_present_o),
  .end_of_text_o  (end_of_text_o),
  .psel           (psel),
  .penable        (penable),
  .pwrite         (pwrite),
  .paddr          (paddr),
  .pwdata         (pwdata),
  .prdata         (prdata)
);

@@ dv/tb_chat_format_code_stripper_top.sv @@
// ----------------------------------------------------------------------------
// Chat format code stripper testbench
// Feeds byte texts through the stripper under random idling and back-pressure,
// predicts output words from the strip select and the parse phase or from a
// directed table, and compares each word field by field. The select
// register is rewritten and read back between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_chat_format_code_stripper_top;
  import cfs_pkg::*;

  localparam logic [AddrW-1:0] BadRegAddr = 3'd4;
  localparam int unsigned      IdleLimit  = 5000;
  localparam int unsigned      LongHold   = 60;
  localparam int unsigned      DrainWait  = 4;
  localparam int unsigned      PhaseWords = 100;
  localparam int unsigned      NumPhases  = 10;
  localparam int unsigned      NumRows    = 27;

  typedef struct packed {
    logic [7:0] b;
    logic       l;
    logic       typed;
    logic [1:0] n;
    result_t    e0;
    result_t    e1;
  } dir_row_t;

  localparam result_t NoRes = '0;

  localparam dir_row_t DirRows [NumRows] = '{
    '{8'h41,      1'b0, 1'b1, 2'd1, '{8'h41, 1'b1, 1'b0}, NoRes},
    '{ChBold,     1'b0, 1'b1, 2'd0, NoRes, NoRes},
    '{ChColor,    1'b0, 1'b1, 2'd0, NoRes, NoRes},
    '{8'h31,      1'b0, 1'b1, 2'd0, NoRes, NoRes},
    '{8'h32,      1'b0, 1'b1, 2'd0, NoRes, NoRes},
    '{ChComma,    1'b0, 1'b1, 2'd0, NoRes, NoRes},
    '{8'h33,      1'b0, 1'b1, 2'd0, NoRes, NoRes},
    '{8'h34,      1'b0, 1'b1, 2'd0, NoRes, NoRes},
    '{8'h78,      1'b1, 1'b1, 2'd1, '{8'h78, 1'b1, 1'b1}, NoRes},
    '{ChColor,    1'b0, 1'b0, 2'd0, NoRes, NoRes},
    '{8'h35,      1'b0, 1'b0, 2'd0, NoRes, NoRes},
    '{ChComma,    1'b0, 1'b0, 2'd0, NoRes, NoRes},
    '{8'h71,      1'b0, 1'b0, 2'd0, NoRes, NoRes},
    '{ChColor,    1'b0, 1'b0, 2'd0, NoRes, NoRes},
    '{8'h37,      1'b0, 1'b0, 2'd0, NoRes, NoRes},
    '{ChComma,    1'b1, 1'b1, 2'd1, '{ChComma, 1'b1, 1'b1}, NoRes},
    '{ChReverse,  1'b1, 1'b1, 2'd1, '{8'h00, 1'b0, 1'b1}, NoRes},
    '{8'h07,      1'b0, 1'b1, 2'd1, '{8'h07, 1'b1, 1'b0}, NoRes},
    '{8'hFF,      1'b0, 1'b1, 2'd1, '{8'hFF, 1'b1, 1'b0}, NoRes},
    '{ChColor,    1'b0, 1'b0, 2'd0, NoRes, NoRes},
    '{ChComma,    1'b0, 1'b0, 2'd0, NoRes, NoRes},
    '{ChColor,    1'b0, 1'b0, 2'd0, NoRes, NoRes},
    '{8'h39,      1'b0, 1'b0, 2'd0, NoRes, NoRes},
    '{ChComma,    1'b0, 1'b0, 2'd0, NoRes, NoRes},
    '{ChUnderline, 1'b0, 1'b0, 2'd0, NoRes, NoRes},
    '{ChPlain,    1'b1, 1'b1, 2'd1, '{8'h00, 1'b0, 1'b1}, NoRes},
    '{8'h01,      1'b1, 1'b1, 2'd1, '{8'h01, 1'b1, 1'b1}, NoRes}
  };

  localparam logic [SelW-1:0] SelPlan [NumPhases] = '{
    6'd0, 6'd63, 6'd1, 6'd2, 6'd4, 6'd8, 6'd16, 6'd32, 6'd31, 6'd0
  };

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [7:0]       text_byte_i;
  logic             text_last_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [7:0]       out_byte_o;
  logic             byte_present_o;
  logic             end_of_text_o;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  chat_format_code_stripper_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .text_byte_i    (text_byte_i),
    .text_last_i    (text_last_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .byte_present_o (byte_present_o),
    .end_of_text_o  (end_of_text_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  phase_e          parse_ph;
  logic [SelW-1:0] strip_sel;
  result_t         stripped_q [$];
  int unsigned     fail_cnt;
  int unsigned     words_sent;
  int unsigned     snd_idle_pct;
  int unsigned     rcv_idle_pct;
  int unsigned     hold_reqs;
  int unsigned     hold_done;
  int unsigned     hold_left;
  int unsigned     quiet_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit code_selected(input logic [7:0] b);
    logic [SelW-1:0] m;
    m = strip_sel[SelAll] ? '1 : strip_sel;
    case (b)
      ChColor:     return m[SelColor];
      ChReverse:   return m[SelRev];
      ChUnderline: return m[SelUnder];
      ChBold:      return m[SelBold];
      ChPlain:     return m[SelPlain];
      default:     return 1'b0;
    endcase
  endfunction

  task automatic take_text(input logic [7:0] b, ref result_t r [$]);
    parse_ph = PhNormal;
    if (code_selected(b)) begin
      if (b == ChColor) parse_ph = PhColor;
    end else begin
      r.push_back('{b, 1'b1, 1'b0});
    end
  endtask

  task automatic strip_step(input logic [7:0] b, input logic l, ref result_t r [$]);
    bit dig;
    dig = (b >= ChDigit0) && (b <= ChDigit9);
    r.delete();
    case (parse_ph)
      PhColor: begin
        if (dig) parse_ph = PhFg1;
        else take_text(b, r);
      end
      PhFg1: begin
        if (dig) parse_ph = PhFg2;
        else if (b == ChComma) parse_ph = PhHeld;
        else take_text(b, r);
      end
      PhFg2: begin
        if (b == ChComma) parse_ph = PhHeld;
        else take_text(b, r);
      end
      PhHeld: begin
        if (dig) begin
          parse_ph = PhBg1;
        end else begin
          r.push_back('{ChComma, 1'b1, 1'b0});
          take_text(b, r);
        end
      end
      PhBg1: begin
        parse_ph = PhNormal;
        if (!dig) take_text(b, r);
      end
      default: take_text(b, r);
    endcase
    if (l) begin
      if (parse_ph == PhHeld) r.push_back('{ChComma, 1'b1, 1'b0});
      parse_ph = PhNormal;
      if (r.size() == 0) r.push_back('{8'h00, 1'b0, 1'b0});
      r[r.size()-1].eot = 1'b1;
    end
  endtask

  // call at a falling edge; returns at the falling edge after acceptance
  task automatic send_word(input logic [7:0] b, input logic l, ref result_t r [$]);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    text_byte_i <= b;
    text_last_i <= l;
    do @(posedge clk_i); while (in_stall_o);
    strip_step(b, l, r);
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_text(input logic [7:0] txt [$]);
    result_t r [$];
    foreach (txt[i]) begin
      send_word(txt[i], i == txt.size() - 1, r);
      foreach (r[k]) stripped_q.push_back(r[k]);
    end
  endtask

  task automatic send_random_text();
    logic [7:0] txt [$];
    logic [7:0] codes [6];
    int unsigned len;
    codes = '{ChBold, ChColor, ChPlain, ChReverse, ChUnderline, 8'h07};
    len = $urandom_range(10, 1);
    while (txt.size() < len) begin
      case ($urandom_range(9))
        0, 1, 2: begin
          txt.push_back(ChColor);
          repeat ($urandom_range(3)) txt.push_back(ChDigit0 + 8'($urandom_range(9)));
          if ($urandom_range(2) != 0) begin
            txt.push_back(ChComma);
            repeat ($urandom_range(3)) txt.push_back(ChDigit0 + 8'($urandom_range(9)));
          end
        end
        3: txt.push_back(codes[$urandom_range(5)]);
        4: txt.push_back($urandom_range(1) ? ChComma : ChDigit0 + 8'($urandom_range(9)));
        default: txt.push_back(8'($urandom_range(255, 1)));
      endcase
    end
    send_text(txt);
  endtask

  task automatic apb_access(input logic wr, input logic [AddrW-1:0] a,
                            input logic [DataW-1:0] d, output logic [DataW-1:0] q);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= a;
    pwdata  <= d;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    q = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_select();
    logic [DataW-1:0] q;
    apb_access(1'b0, RegStripSelect, '0, q);
    if (q !== DataW'(strip_sel)) begin
      if (fail_cnt < 10)
        $display("select readback: expected %0h got %0h", strip_sel, q);
      fail_cnt++;
    end
  endtask

  // drain, then rewrite the select with junk in the high bits and read it back
  task automatic load_select(input logic [SelW-1:0] v);
    logic [DataW-1:0] q;
    logic [DataW-1:0] junk;
    in_valid_i <= 1'b0;
    wait (stripped_q.size() == 0);
    @(negedge clk_i);
    repeat (DrainWait) @(negedge clk_i);
    junk = {{(DataW-SelW){1'b1}}, {SelW{1'b0}}} & $urandom;
    apb_access(1'b1, RegStripSelect, junk | DataW'(v), q);
    strip_sel = v;
    apb_access(1'b1, BadRegAddr, $urandom, q);
    check_select();
  endtask

  always @(negedge clk_i) begin
    if (hold_reqs != hold_done) begin
      hold_done   = hold_reqs;
      hold_left   = LongHold;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rcv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{out_byte_o, byte_present_o, end_of_text_o};
      if (stripped_q.size() == 0) begin
        if (fail_cnt < 10)
          $display("unexpected word: byte %0h present %0b end %0b",
                   got.data, got.present, got.eot);
        fail_cnt++;
      end else begin
        want = stripped_q.pop_front();
        if (got.data !== want.data || got.present !== want.present ||
            got.eot !== want.eot) begin
          if (fail_cnt < 10)
            $display("mismatch: expected byte %0h present %0b end %0b, got %0h %0b %0b",
                     want.data, want.present, want.eot, got.data, got.present, got.eot);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else if (quiet_cycles >= IdleLimit) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles++;
    end
  end

  initial begin
    result_t r [$];
    dir_row_t row;
    int unsigned target;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    text_byte_i  = '0;
    text_last_i  = 1'b0;
    out_stall_i  = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    fail_cnt     = 0;
    words_sent   = 0;
    hold_reqs    = 0;
    hold_done    = 0;
    hold_left    = 0;
    quiet_cycles = 0;
    snd_idle_pct = 9;
    rcv_idle_pct = 47;
    parse_ph     = PhNormal;
    strip_sel    = SelReset;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    check_select();

    for (int i = 0; i < NumRows; i++) begin
      row = DirRows[i];
      send_word(row.b, row.l, r);
      if (row.typed) begin
        r.delete();
        if (row.n > 0) r.push_back(row.e0);
        if (row.n > 1) r.push_back(row.e1);
      end
      foreach (r[k]) stripped_q.push_back(r[k]);
    end

    for (int p = 0; p < NumPhases; p++) begin
      snd_idle_pct = (p < 4) ? 9 : (p < 7) ? 47 : 0;
      rcv_idle_pct = (p < 4) ? 47 : (p < 7) ? 9 : 0;
      load_select(p == NumPhases - 1 ? SelW'($urandom_range(63)) : SelPlan[p]);
      if (p == 1 || p == 8) hold_reqs++;
      target = words_sent + PhaseWords;
      while (words_sent < target) send_random_text();
    end

    in_valid_i <= 1'b0;
    wait (stripped_q.size() == 0);
    repeat (10) @(posedge clk_i);
    fail_cnt += stripped_q.size();
    if (fail_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ chat_format_code_stripper_top.f @@
+incdir+hdl
hdl/cfs_pkg.sv
hdl/cfs_parser.sv
hdl/cfs_out_fifo.sv
hdl/chat_format_code_stripper_top.sv
hdl/cfs_checker.sv
dv/tb_chat_format_code_stripper_top.sv
